FILE: sv/wcg_pkg.sv
// Package for the weak composition generator.
// Holds shared widths, command and state codes, and the structs between modules.
// No dependencies.
package wcg_pkg;

  // Default sizing of the parts store
  localparam int MAX_PARTS_DEF   = 8;
  localparam int VALUE_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int PART_COUNT_W = 4;
  localparam int TOTAL_W      = 8;
  localparam int INDEX_W      = 3;
  localparam int PART_VALUE_W = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd1;

  // Reset values of the configuration registers
  localparam logic [PART_COUNT_W-1:0] PART_COUNT_RST = 4'd1;
  localparam logic [TOTAL_W-1:0]      TOTAL_RST      = 8'd0;

  typedef enum logic {
    CMD_STEP    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [PART_COUNT_W-1:0] part_count;
    logic [TOTAL_W-1:0]      total;
  } cfg_t;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } cmd_t;

endpackage

FILE: sv/wcg_front.sv
// Front end of the weak composition generator: input handshake and command queue.
// Classifies each input transfer as restart or step and queues it for the back end.
// Depends on wcg_pkg.
module wcg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          restart_i,
  output wcg_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import wcg_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_e            q_mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;
  cmd_e            in_cmd;

  // Classify the incoming item
  assign in_cmd = restart_i ? CMD_RESTART : CMD_STEP;

  assign in_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = cmd_pop_i && (cnt_q != '0);

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = q_mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

FILE: sv/wcg_back.sv
// Back end of the weak composition generator: parts store, step sequencer, output.
// Scans serially, applies one lexicographic step or loads the first, emits parts.
// Depends on wcg_pkg.
module wcg_back #(
  parameter int MAX_PARTS   = wcg_pkg::MAX_PARTS_DEF,
  parameter int VALUE_WIDTH = wcg_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wcg_pkg::cfg_t                    cfg_i,
  input  wcg_pkg::cmd_t                    cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wcg_pkg::INDEX_W-1:0]      part_index_o,
  output logic [wcg_pkg::PART_VALUE_W-1:0] part_value_o,
  output logic                             last_part_o,
  output logic                             final_composition_o
);
  import wcg_pkg::*;

  localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int KW = $clog2(MAX_PARTS + 1);
  localparam int SW = VALUE_WIDTH + IW + 1;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] parts_q [MAX_PARTS];
  logic [VALUE_WIDTH-1:0] parts_d [MAX_PARTS];
  logic                   first_q, first_d;
  logic                   done_q, done_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [IW-1:0]          pos_q, pos_d;
  logic [SW-1:0]          sum_q, sum_d;
  logic [SW-1:0]          presum_q, presum_d;

  logic [KW-1:0]          k_eff;
  logic [IW-1:0]          km1;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] scan_val;
  logic [IW-1:0]          pm1;
  logic                   inc;
  logic [SW-1:0]          rest;
  logic [VALUE_WIDTH-1:0] tail;
  logic                   is_last;

  // Effective part count: zero counts as one, clamp at the store size
  always_comb begin
    if (cfg_i.part_count == '0) begin
      k_eff = KW'(1);
    end else if (int'(cfg_i.part_count) > MAX_PARTS) begin
      k_eff = KW'(MAX_PARTS);
    end else begin
      k_eff = KW'(cfg_i.part_count);
    end
  end

  assign km1      = IW'(k_eff - KW'(1));
  assign n        = VALUE_WIDTH'(cfg_i.total);
  assign scan_val = parts_q[idx_q];
  assign is_last  = (idx_q == km1);

  // Step arithmetic: bump the part left of the last nonzero one, refill the tail
  assign pm1  = pos_q - IW'(1);
  assign inc  = (parts_q[pm1] != '1);
  assign rest = presum_q + SW'(inc);
  assign tail = (rest > SW'(n)) ? '0 : VALUE_WIDTH'(SW'(n) - rest);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = (cmd_i.cmd == CMD_RESTART || first_q) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs and output payload
  always_comb begin
    cmd_pop_o           = (state_q == ST_IDLE) && cmd_i.valid;
    out_valid_o         = (state_q == ST_EMIT);
    part_index_o        = INDEX_W'(idx_q);
    part_value_o        = PART_VALUE_W'(parts_q[idx_q]);
    last_part_o         = is_last;
    final_composition_o = done_q;
  end

  // Datapath
  always_comb begin
    parts_d  = parts_q;
    first_d  = first_q;
    done_d   = done_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    presum_d = presum_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_i.cmd == CMD_RESTART) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
              parts_d[i] = '0;
            end
            first_d = 1'b1;
          end
          idx_d    = '0;
          pos_d    = '0;
          sum_d    = '0;
          presum_d = '0;
        end
      end
      // Find the last nonzero part above index zero and the sum below it
      ST_SCAN: begin
        if (scan_val != '0 && idx_q != '0) begin
          pos_d    = idx_q;
          presum_d = sum_q;
        end
        sum_d = sum_q + SW'(scan_val);
        if (!is_last) begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_APPLY: begin
        for (int i = 0; i < MAX_PARTS; i++) begin
          if (first_q) begin
            if (IW'(i) < km1) begin
              parts_d[i] = '0;
            end else if (IW'(i) == km1) begin
              parts_d[i] = n;
            end
          end else if (pos_q != '0) begin
            if (IW'(i) == pm1) begin
              parts_d[i] = parts_q[i] + VALUE_WIDTH'(inc);
            end else if (IW'(i) >= pos_q && IW'(i) < km1) begin
              parts_d[i] = '0;
            end else if (IW'(i) == km1) begin
              parts_d[i] = tail;
            end
          end
        end
        first_d = 1'b0;
        done_d  = (parts_d[0] == n);
        idx_d   = '0;
      end
      ST_EMIT: begin
        if (out_ready_i && !is_last) begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < MAX_PARTS; i++) begin
        parts_q[i] <= '0;
      end
      first_q  <= 1'b1;
      done_q   <= 1'b0;
      idx_q    <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      presum_q <= '0;
    end else begin
      state_q  <= state_d;
      parts_q  <= parts_d;
      first_q  <= first_d;
      done_q   <= done_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      presum_q <= presum_d;
    end
  end

  // A stalled output holds its part
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_ready_i) |=> (state_q == ST_EMIT && $stable(idx_q)))
    else $error("output part moved while stalled");

  // Counter never runs past the last part while scanning or emitting
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_EMIT) |-> (idx_q <= km1))
    else $error("part counter beyond part count");

  // A command is taken only when the back end is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_SCAN || state_q == ST_APPLY))
    else $error("command taken without starting a step");

  // The first composition is consumed by the apply cycle
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (!first_q && state_q == ST_EMIT))
    else $error("first-pending flag not cleared by step");

endmodule

FILE: sv/weak_composition_generator.sv
// Weak composition generator: each input transfer (restart or step) produces
// one output transfer per part of the current composition, part 0 first.
// After the command leaves the two-entry input queue, the back end goes from
// idle to a serial scan of the stored parts (skipped for the first composition
// after reset or restart), to an apply state that makes the step or loads the
// first composition, and to an emit state with k output transfers, k being the
// effective part count. The output gives one part per cycle while out_ready_i
// is high. No clearing pass runs after reset. Configuration is to be written
// only while idle by the user; the block itself does not enforce this.
// Depends on wcg_pkg, wcg_front and wcg_back.
module weak_composition_generator #(
  parameter int MAX_PARTS   = wcg_pkg::MAX_PARTS_DEF,
  parameter int VALUE_WIDTH = wcg_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wcg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wcg_pkg::INDEX_W-1:0]      part_index_o,
  output logic [wcg_pkg::PART_VALUE_W-1:0] part_value_o,
  output logic                             last_part_o,
  output logic                             final_composition_o
);
  import wcg_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PART_COUNT: cfg_d.part_count = cfg_data_i[PART_COUNT_W-1:0];
        CFG_TOTAL:      cfg_d.total      = cfg_data_i[TOTAL_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.part_count <= PART_COUNT_RST;
      cfg_q.total      <= TOTAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  wcg_back #(
    .MAX_PARTS   (MAX_PARTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .cmd_pop_o           (cmd_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .part_index_o        (part_index_o),
    .part_value_o        (part_value_o),
    .last_part_o         (last_part_o),
    .final_composition_o (final_composition_o)
  );

endmodule
